### rtl/core/guided_firefly_outlier_filter_macros.svh
`ifndef GUIDED_FIREFLY_OUTLIER_FILTER_MACROS_SVH
`define GUIDED_FIREFLY_OUTLIER_FILTER_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define GFOF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gfof: check failed");

// next-cycle implication, clocked on clk, off during reset
`define GFOF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gfof: check failed");

`endif

### rtl/core/gfof_pkg.sv
package gfof_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int LINE_AW    = $clog2(MAX_WIDTH);
    localparam int DIV_W      = 47;

    localparam logic [14:0] TC_A = 15'd25395;
    localparam logic [19:0] TC_B = 20'd524288;
    localparam logic [20:0] TC_C = 21'd1782579;
    localparam logic [23:0] TC_E = 24'd16106127;

    typedef struct packed {
        logic        [15:0] radiance_red;
        logic        [15:0] radiance_green;
        logic        [15:0] radiance_blue;
        logic        [14:0] albedo_red;
        logic        [14:0] albedo_green;
        logic        [14:0] albedo_blue;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
    } pixel_t;

    typedef struct packed {
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
        logic        was_replaced;
        logic        last_of_run;
        logic        end_of_frame;
    } result_t;

    typedef struct packed {
        logic [2:0][15:0] rad;
        logic [2:0][14:0] alb;
        logic [2:0][15:0] nrm;
        logic [15:0]      gray;
    } pix_t;

    typedef enum logic [2:0] {
        CFG_FRAME_WIDTH      = 3'd0,
        CFG_FRAME_HEIGHT     = 3'd1,
        CFG_ALBEDO_LIMIT     = 3'd2,
        CFG_NORMAL_LIMIT     = 3'd3,
        CFG_DEVIATION_FACTOR = 3'd4
    } cfg_index_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TONE_A,
        ST_TONE_N,
        ST_TONE_D,
        ST_TONE_GO,
        ST_TONE_WAIT,
        ST_LINE_RD,
        ST_SHIFT,
        ST_PICK,
        ST_JSTART,
        ST_NB_FETCH,
        ST_NB_DIST,
        ST_NB_ACC,
        ST_DEC1,
        ST_DEC2,
        ST_DEC3,
        ST_DEC4,
        ST_DEC5,
        ST_BRANCH,
        ST_REP_GO,
        ST_REP_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       load_in;
        logic       tone_a;
        logic       tone_n;
        logic       tone_d;
        logic       div_start;
        logic       div_rep;
        logic       gray_acc;
        logic       line_rd;
        logic       shift;
        logic       jstart;
        logic       nb_fetch;
        logic       nb_dist;
        logic       nb_acc;
        logic       dec1;
        logic       dec2;
        logic       dec3;
        logic       dec4;
        logic       dec5;
        logic       rep_store;
        logic       emit;
        logic       last;
        logic [1:0] chan;
        logic [1:0] comp;
        logic [3:0] nb;
        logic [1:0] slot;
    } gfof_cmd_t;

    typedef struct packed {
        logic       div_done;
        logic       out_free;
        logic [3:0] slot_en;
        logic       repl;
    } gfof_status_t;

    function automatic logic [15:0] luma_coef(input logic [1:0] k);
        logic [15:0] c;
        case (k)
            2'd0:    c = 16'd19589;
            2'd1:    c = 16'd38470;
            default: c = 16'd7471;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] nb_row(input logic [3:0] nb);
        logic [1:0] r;
        case (nb) inside
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] nb_col(input logic [3:0] nb);
        logic [1:0] c;
        case (nb) inside
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

endpackage

### rtl/core/gfof_divider.sv
module gfof_divider
    import gfof_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] hi,
    input  logic [15:0]      lo,
    input  logic [DIV_W-1:0] den,
    output logic             done,
    output logic [15:0]      quot
);

    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] den_reg;
    logic [15:0]      lo_reg;
    logic [15:0]      q_reg;
    logic [3:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DIV_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, lo_reg[15]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 4'd1;
            if (cnt_reg == 4'd15)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= hi;
            lo_reg  <= lo;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DIV_W'(trial - {1'b0, den_reg}) : trial[DIV_W-1:0];
            lo_reg  <= {lo_reg[14:0], 1'b0};
            q_reg   <= {q_reg[14:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

### rtl/core/gfof_datapath.sv
module gfof_datapath
    import gfof_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  pixel_t       pixel,
    output result_t      result,
    output logic         result_valid,
    input  logic         result_stall,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  gfof_cmd_t    cmd,
    output gfof_status_t status
);

    logic [12:0] width_reg, height_reg;
    logic [31:0] alim_reg, nlim_reg;
    logic [7:0]  fac_reg;
    logic [11:0] col_cnt_reg, row_cnt_reg;
    logic [12:0] ew, eh;
    logic [11:0] wl, hl;
    logic [11:0] c_eff, r_eff;
    logic        cfg_we;

    pix_t        in_pix_reg;
    logic [11:0] c_reg, r_reg;
    logic [15:0] x_val;
    logic [30:0] ax_reg;
    logic [DIV_W-1:0] num_reg, den_reg;
    logic [31:0] gacc_reg;

    pix_t        line0_mem [0:MAX_WIDTH-1];
    pix_t        line1_mem [0:MAX_WIDTH-1];
    pix_t        rd0_reg, rd1_reg;
    pix_t        win_reg [0:2][0:2];
    pix_t        new_pix;

    pix_t        ctr_reg, nb_pix_reg;
    logic        cr_hi_reg, cc_hi_reg;
    logic [11:0] tr_reg, tc_reg;
    logic [1:0]  nr, nc, wr, wc;
    logic        row_ok, col_ok, nb_ok_reg;

    logic signed [15:0] da;
    logic signed [31:0] da_sq;
    logic signed [16:0] dn;
    logic signed [33:0] dn_sq;
    logic [31:0] ad_reg;
    logic [33:0] nd_reg;

    logic [3:0]  n_reg;
    logic [18:0] s_reg;
    logic [34:0] p_reg;
    logic [2:0][18:0] sum_reg;

    logic [18:0] ng_reg, d_reg;
    logic [37:0] ssq_reg, np_reg, var_reg, dd_reg;
    logic [15:0] ff_reg;
    logic [19:0] fn_reg;
    logic [38:0] rlo_reg, rhi;
    logic [40:0] dd_m;
    logic [48:0] lhs_reg;
    logic [57:0] rhs_reg;
    logic        repl_reg;
    logic [2:0][15:0] rep_q_reg;

    logic [19:0] rep_m;
    logic [DIV_W-1:0] div_hi, div_den;
    logic [15:0] div_lo, quot;
    logic        div_done;

    result_t     result_reg;
    logic        result_valid_reg;

    assign ew = (width_reg == 13'd0) ? 13'd1 :
                (width_reg > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : width_reg;
    assign eh = (height_reg == 13'd0) ? 13'd1 :
                (height_reg > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : height_reg;
    assign wl = 12'(ew - 13'd1);
    assign hl = 12'(eh - 13'd1);
    assign c_eff = ({1'b0, col_cnt_reg} >= ew) ? 12'd0 : col_cnt_reg;
    assign r_eff = ({1'b0, row_cnt_reg} >= eh) ? 12'd0 : row_cnt_reg;
    assign cfg_we = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= 13'd1920;
            height_reg  <= 13'd1080;
            alim_reg    <= 32'd26843546;
            nlim_reg    <= 32'd26843546;
            fac_reg     <= 8'd48;
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:
                begin
                    width_reg   <= cfg_data[12:0];
                    col_cnt_reg <= '0;
                    row_cnt_reg <= '0;
                end
                CFG_FRAME_HEIGHT:
                begin
                    height_reg  <= cfg_data[12:0];
                    col_cnt_reg <= '0;
                    row_cnt_reg <= '0;
                end
                CFG_ALBEDO_LIMIT:     alim_reg <= cfg_data;
                CFG_NORMAL_LIMIT:     nlim_reg <= cfg_data;
                CFG_DEVIATION_FACTOR: fac_reg  <= cfg_data[7:0];
                default:              ;
            endcase
        end
        else if (cmd.load_in)
        begin
            if (c_eff == wl)
            begin
                col_cnt_reg <= '0;
                row_cnt_reg <= (r_eff == hl) ? 12'd0 : r_eff + 12'd1;
            end
            else
            begin
                col_cnt_reg <= c_eff + 12'd1;
                row_cnt_reg <= r_eff;
            end
        end
    end

    assign x_val = (in_pix_reg.rad[cmd.chan] == 16'd0) ? 16'd0
                 : in_pix_reg.rad[cmd.chan] - 16'd1;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_pix_reg.rad[0] <= pixel.radiance_red;
            in_pix_reg.rad[1] <= pixel.radiance_green;
            in_pix_reg.rad[2] <= pixel.radiance_blue;
            in_pix_reg.alb[0] <= pixel.albedo_red;
            in_pix_reg.alb[1] <= pixel.albedo_green;
            in_pix_reg.alb[2] <= pixel.albedo_blue;
            in_pix_reg.nrm[0] <= pixel.normal_x;
            in_pix_reg.nrm[1] <= pixel.normal_y;
            in_pix_reg.nrm[2] <= pixel.normal_z;
            in_pix_reg.gray   <= '0;
            c_reg             <= c_eff;
            r_reg             <= r_eff;
            gacc_reg          <= '0;
        end
        if (cmd.tone_a)
            ax_reg <= 31'({16'd0, TC_A} * {15'd0, x_val});
        if (cmd.tone_n)
            num_reg <= DIV_W'({31'd0, x_val} * ({16'd0, ax_reg} + DIV_W'(TC_B)));
        if (cmd.tone_d)
            den_reg <= DIV_W'({31'd0, x_val} * ({16'd0, ax_reg} + DIV_W'(TC_C)))
                     + DIV_W'(TC_E);
        if (cmd.gray_acc)
            gacc_reg <= gacc_reg + 32'({16'd0, quot} * {16'd0, luma_coef(cmd.chan)});
    end

    always_comb
    begin
        new_pix      = in_pix_reg;
        new_pix.gray = gacc_reg[31:16];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.line_rd)
        begin
            rd0_reg <= line0_mem[c_reg];
            rd1_reg <= line1_mem[c_reg];
        end
        if (cmd.shift)
        begin
            line0_mem[c_reg] <= rd1_reg;
            line1_mem[c_reg] <= new_pix;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= rd0_reg;
            win_reg[1][2] <= rd1_reg;
            win_reg[2][2] <= new_pix;
        end
    end

    assign nr = nb_row(cmd.nb);
    assign nc = nb_col(cmd.nb);
    assign wr = (cr_hi_reg && nr != 2'd2) ? nr + 2'd1 : (cr_hi_reg ? 2'd2 : nr);
    assign wc = (cc_hi_reg && nc != 2'd2) ? nc + 2'd1 : (cc_hi_reg ? 2'd2 : nc);
    assign row_ok = (nr == 2'd0) ? (tr_reg != 12'd0) :
                    (nr == 2'd2) ? (tr_reg != hl && !cr_hi_reg) : 1'b1;
    assign col_ok = (nc == 2'd0) ? (tc_reg != 12'd0) :
                    (nc == 2'd2) ? (tc_reg != wl && !cc_hi_reg) : 1'b1;

    assign da    = $signed({1'b0, nb_pix_reg.alb[cmd.comp]})
                 - $signed({1'b0, ctr_reg.alb[cmd.comp]});
    assign da_sq = da * da;
    assign dn    = $signed({nb_pix_reg.nrm[cmd.comp][15], nb_pix_reg.nrm[cmd.comp]})
                 - $signed({ctr_reg.nrm[cmd.comp][15], ctr_reg.nrm[cmd.comp]});
    assign dn_sq = dn * dn;

    always_ff @(posedge clk)
    begin
        if (cmd.jstart)
        begin
            cr_hi_reg <= cmd.slot[0];
            cc_hi_reg <= cmd.slot[1];
            tr_reg    <= cmd.slot[0] ? r_reg : r_reg - 12'd1;
            tc_reg    <= cmd.slot[1] ? c_reg : c_reg - 12'd1;
            ctr_reg   <= win_reg[cmd.slot[0] ? 2'd2 : 2'd1][cmd.slot[1] ? 2'd2 : 2'd1];
            n_reg     <= '0;
            s_reg     <= '0;
            p_reg     <= '0;
            sum_reg   <= '0;
        end
        if (cmd.nb_fetch)
        begin
            nb_pix_reg <= win_reg[wr][wc];
            nb_ok_reg  <= row_ok && col_ok;
            ad_reg     <= '0;
            nd_reg     <= '0;
        end
        if (cmd.nb_dist)
        begin
            ad_reg <= ad_reg + {2'd0, da_sq[29:0]};
            nd_reg <= nd_reg + {2'd0, dn_sq[31:0]};
        end
        if (cmd.nb_acc && nb_ok_reg && ad_reg < alim_reg && nd_reg < {2'd0, nlim_reg})
        begin
            n_reg <= n_reg + 4'd1;
            s_reg <= s_reg + {3'd0, nb_pix_reg.gray};
            p_reg <= p_reg + 35'({16'd0, nb_pix_reg.gray} * {16'd0, nb_pix_reg.gray});
            for (int k = 0; k < 3; k++)
                sum_reg[k] <= sum_reg[k] + {3'd0, nb_pix_reg.rad[k]};
        end
    end

    assign dd_m = 41'({3'd0, dd_reg} * {37'd0, n_reg - 4'd1});
    assign rhi  = 39'({19'd0, fn_reg} * {20'd0, var_reg[37:19]});

    always_ff @(posedge clk)
    begin
        if (cmd.dec1)
        begin
            ng_reg  <= 19'({15'd0, n_reg} * {3'd0, ctr_reg.gray});
            ssq_reg <= 38'({19'd0, s_reg} * {19'd0, s_reg});
            np_reg  <= 38'({34'd0, n_reg} * {3'd0, p_reg});
            ff_reg  <= 16'({8'd0, fac_reg} * {8'd0, fac_reg});
        end
        if (cmd.dec2)
        begin
            d_reg   <= (ng_reg >= s_reg) ? ng_reg - s_reg : s_reg - ng_reg;
            var_reg <= np_reg - ssq_reg;
            fn_reg  <= 20'({4'd0, ff_reg} * {16'd0, n_reg});
        end
        if (cmd.dec3)
        begin
            dd_reg  <= 38'({19'd0, d_reg} * {19'd0, d_reg});
            rlo_reg <= 39'({19'd0, fn_reg} * {20'd0, var_reg[18:0]});
        end
        if (cmd.dec4)
        begin
            lhs_reg <= {dd_m, 8'd0};
            rhs_reg <= {19'd0, rlo_reg} + {rhi, 19'd0};
        end
        if (cmd.rep_store && div_done)
            rep_q_reg[cmd.chan] <= quot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            repl_reg <= 1'b0;
        else if (cmd.dec5)
        begin
            if (n_reg == 4'd1)
                repl_reg <= {3'd0, ctr_reg.gray} != s_reg;
            else if (n_reg >= 4'd2)
                repl_reg <= {9'd0, lhs_reg} > rhs_reg;
            else
                repl_reg <= 1'b0;
        end
    end

    assign rep_m   = {1'b0, sum_reg[cmd.chan]} + {17'd0, n_reg[3:1]};
    assign div_hi  = cmd.div_rep ? {{(DIV_W-4){1'b0}}, rep_m[19:16]} : num_reg;
    assign div_lo  = cmd.div_rep ? rep_m[15:0] : 16'd0;
    assign div_den = cmd.div_rep ? {{(DIV_W-4){1'b0}}, n_reg} : den_reg;

    gfof_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .hi    (div_hi),
        .lo    (div_lo),
        .den   (div_den),
        .done  (div_done),
        .quot  (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (cmd.emit)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg.out_red      <= repl_reg ? rep_q_reg[0] : ctr_reg.rad[0];
            result_reg.out_green    <= repl_reg ? rep_q_reg[1] : ctr_reg.rad[1];
            result_reg.out_blue     <= repl_reg ? rep_q_reg[2] : ctr_reg.rad[2];
            result_reg.was_replaced <= repl_reg;
            result_reg.last_of_run  <= cmd.last;
            result_reg.end_of_frame <= (tr_reg == hl) && (tc_reg == wl);
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    assign status.div_done   = div_done;
    assign status.out_free   = !result_valid_reg || !result_stall;
    assign status.slot_en[0] = (c_reg != 12'd0) && (r_reg != 12'd0);
    assign status.slot_en[1] = (c_reg != 12'd0) && (r_reg == hl);
    assign status.slot_en[2] = (c_reg == wl) && (r_reg != 12'd0);
    assign status.slot_en[3] = (c_reg == wl) && (r_reg == hl);
    assign status.repl       = repl_reg;

endmodule

### rtl/core/gfof_ctrl.sv
module gfof_ctrl
    import gfof_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         pixel_valid,
    input  gfof_status_t status,
    output logic         idle,
    output gfof_cmd_t    cmd
);

    state_t     state_reg, state_next;
    logic [1:0] chan_reg, chan_next;
    logic [1:0] comp_reg, comp_next;
    logic [3:0] nb_reg, nb_next;
    logic [2:0] slot_reg, slot_next;
    logic       more;

    always_comb
    begin
        case (slot_reg[1:0])
            2'd0:    more = |status.slot_en[3:1];
            2'd1:    more = |status.slot_en[3:2];
            2'd2:    more = status.slot_en[3];
            default: more = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chan_reg  <= '0;
            comp_reg  <= '0;
            nb_reg    <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
            comp_reg  <= comp_next;
            nb_reg    <= nb_next;
            slot_reg  <= slot_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        comp_next  = comp_reg;
        nb_next    = nb_reg;
        slot_next  = slot_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pixel_valid)
                begin
                    state_next = ST_TONE_A;
                    chan_next  = '0;
                end
            end
            ST_TONE_A:  state_next = ST_TONE_N;
            ST_TONE_N:  state_next = ST_TONE_D;
            ST_TONE_D:  state_next = ST_TONE_GO;
            ST_TONE_GO: state_next = ST_TONE_WAIT;
            ST_TONE_WAIT:
            begin
                if (status.div_done)
                begin
                    if (chan_reg == 2'd2)
                        state_next = ST_LINE_RD;
                    else
                    begin
                        chan_next  = chan_reg + 2'd1;
                        state_next = ST_TONE_A;
                    end
                end
            end
            ST_LINE_RD: state_next = ST_SHIFT;
            ST_SHIFT:
            begin
                state_next = ST_PICK;
                slot_next  = '0;
            end
            ST_PICK:
            begin
                if (slot_reg[2])
                    state_next = ST_IDLE;
                else if (status.slot_en[slot_reg[1:0]])
                    state_next = ST_JSTART;
                else
                    slot_next = slot_reg + 3'd1;
            end
            ST_JSTART:
            begin
                state_next = ST_NB_FETCH;
                nb_next    = '0;
            end
            ST_NB_FETCH:
            begin
                state_next = ST_NB_DIST;
                comp_next  = '0;
            end
            ST_NB_DIST:
            begin
                if (comp_reg == 2'd2)
                    state_next = ST_NB_ACC;
                else
                    comp_next = comp_reg + 2'd1;
            end
            ST_NB_ACC:
            begin
                if (nb_reg == 4'd8)
                    state_next = ST_DEC1;
                else
                begin
                    nb_next    = (nb_reg == 4'd3) ? 4'd5 : nb_reg + 4'd1;
                    state_next = ST_NB_FETCH;
                end
            end
            ST_DEC1: state_next = ST_DEC2;
            ST_DEC2: state_next = ST_DEC3;
            ST_DEC3: state_next = ST_DEC4;
            ST_DEC4: state_next = ST_DEC5;
            ST_DEC5: state_next = ST_BRANCH;
            ST_BRANCH:
            begin
                if (status.repl)
                begin
                    state_next = ST_REP_GO;
                    chan_next  = '0;
                end
                else
                    state_next = ST_EMIT;
            end
            ST_REP_GO: state_next = ST_REP_WAIT;
            ST_REP_WAIT:
            begin
                if (status.div_done)
                begin
                    if (chan_reg == 2'd2)
                        state_next = ST_EMIT;
                    else
                    begin
                        chan_next  = chan_reg + 2'd1;
                        state_next = ST_REP_GO;
                    end
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    slot_next  = slot_reg + 3'd1;
                    state_next = ST_PICK;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.chan = chan_reg;
        cmd.comp = comp_reg;
        cmd.nb   = nb_reg;
        cmd.slot = slot_reg[1:0];
        cmd.last = !more;
        idle     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                idle        = 1'b1;
                cmd.load_in = pixel_valid;
            end
            ST_TONE_A:    cmd.tone_a = 1'b1;
            ST_TONE_N:    cmd.tone_n = 1'b1;
            ST_TONE_D:    cmd.tone_d = 1'b1;
            ST_TONE_GO:   cmd.div_start = 1'b1;
            ST_TONE_WAIT: cmd.gray_acc = status.div_done;
            ST_LINE_RD:   cmd.line_rd = 1'b1;
            ST_SHIFT:     cmd.shift = 1'b1;
            ST_JSTART:    cmd.jstart = 1'b1;
            ST_NB_FETCH:  cmd.nb_fetch = 1'b1;
            ST_NB_DIST:   cmd.nb_dist = 1'b1;
            ST_NB_ACC:    cmd.nb_acc = 1'b1;
            ST_DEC1:      cmd.dec1 = 1'b1;
            ST_DEC2:      cmd.dec2 = 1'b1;
            ST_DEC3:      cmd.dec3 = 1'b1;
            ST_DEC4:      cmd.dec4 = 1'b1;
            ST_DEC5:      cmd.dec5 = 1'b1;
            ST_REP_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_rep   = 1'b1;
            end
            ST_REP_WAIT:
            begin
                cmd.div_rep   = 1'b1;
                cmd.rep_store = status.div_done;
            end
            ST_EMIT:      cmd.emit = status.out_free;
            default:      ;
        endcase
    end

endmodule

### rtl/core/guided_firefly_outlier_filter.sv
// A pixel is accepted only while the block is idle, so a new pixel waits until
// every result of the last one is emitted; at most four results per pixel.
// Processing time is set by the shared 16-step divider (three tone-curve
// divisions per pixel, three more per replaced result), by the eight-neighbor
// sequencer (fetch, per-component distance, accumulate) and by result stalls.
// Reset: control, counters, config and flags clear; line stores and data do not.
`include "guided_firefly_outlier_filter_macros.svh"

module guided_firefly_outlier_filter
    import gfof_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_valid,
    output logic        pixel_stall,
    input  pixel_t      pixel,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    gfof_cmd_t    cmd;
    gfof_status_t status;
    logic         idle;

    assign pixel_stall = !idle;
    assign cfg_ready   = 1'b1;

    gfof_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .status      (status),
        .idle        (idle),
        .cmd         (cmd)
    );

    gfof_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel        (pixel),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status)
    );

    `GFOF_ASSERT_NEXT(a_accept_busy, pixel_valid && !pixel_stall, pixel_stall)
    `GFOF_ASSERT_SAME(a_emit_free, cmd.emit, !result_valid || !result_stall)
    `GFOF_ASSERT_NEXT(a_div_restart, cmd.div_start, !status.div_done)

endmodule

### tb/tb.sv
module tb;
    import gfof_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LIMIT_CYCLES = 4000000;
    localparam int          SETTLE       = 600;
    localparam logic [2:0]  CFG_SPARE    = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        pixel_valid = 1'b0;
    logic        pixel_stall;
    pixel_t      pixel = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    guided_firefly_outlier_filter u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    pixel_t  pending_pixels[$];
    result_t expected_results[$];
    int      send_idle = 0;
    int      recv_idle = 0;
    int      hold_left = 0;
    int      error_count = 0;
    int      items_sent = 0;
    int      results_checked = 0;
    int      replaced_seen = 0;
    int      cycle_count = 0;
    logic    pix_taken = 1'b0;

    // mirror of the block
    logic [12:0]     fr_width = 13'd1920;
    logic [12:0]     fr_height = 13'd1080;
    logic [31:0]     alb_lim = 32'd26843546;
    logic [31:0]     nrm_lim = 32'd26843546;
    logic [7:0]      dev_factor = 8'd48;
    int              col_pos = 0;
    int              row_pos = 0;
    pixel_t          upper_line[MAX_WIDTH];
    pixel_t          middle_line[MAX_WIDTH];
    pixel_t          win[3][3];

    logic [15:0]     base_rad;
    logic [14:0]     base_alb;
    logic [15:0]     base_nrm;

    function automatic longint unsigned rad_of(pixel_t p, int k);
        case (k)
            0:       return p.radiance_red;
            1:       return p.radiance_green;
            default: return p.radiance_blue;
        endcase
    endfunction

    function automatic longint alb_of(pixel_t p, int k);
        case (k)
            0:       return longint'(p.albedo_red);
            1:       return longint'(p.albedo_green);
            default: return longint'(p.albedo_blue);
        endcase
    endfunction

    function automatic longint nrm_of(pixel_t p, int k);
        case (k)
            0:       return longint'(p.normal_x);
            1:       return longint'(p.normal_y);
            default: return longint'(p.normal_z);
        endcase
    endfunction

    function automatic longint unsigned tone_map(longint unsigned r);
        longint unsigned x, num, den;
        x   = (r != 0) ? r - 1 : 0;
        num = x * (longint'(TC_A) * x + longint'(TC_B));
        den = x * (longint'(TC_A) * x + longint'(TC_C)) + longint'(TC_E);
        return (num << 16) / den;
    endfunction

    function automatic longint unsigned gray_of(pixel_t p);
        return (64'd19589 * tone_map(rad_of(p, 0)) + 64'd38470 * tone_map(rad_of(p, 1))
                + 64'd7471 * tone_map(rad_of(p, 2))) >> 16;
    endfunction

    function automatic int eff_width();
        int v;
        v = (fr_width == 0) ? 1 : int'(fr_width);
        return (v > MAX_WIDTH) ? MAX_WIDTH : v;
    endfunction

    function automatic int eff_height();
        int v;
        v = (fr_height == 0) ? 1 : int'(fr_height);
        return (v > MAX_HEIGHT) ? MAX_HEIGHT : v;
    endfunction

    function automatic result_t judge_pixel(int cr, int cc, int tr, int tc, int w, int h);
        result_t         res;
        pixel_t          ctr, q;
        longint unsigned n, s, p2, g, ad, nd, gv, ng, d, lhs, rhs, f;
        longint unsigned sum[3];
        longint          da, dn;
        logic            repl;
        int              wr, wc;
        ctr = win[cr][cc];
        n = 0; s = 0; p2 = 0;
        sum[0] = 0; sum[1] = 0; sum[2] = 0;
        g = gray_of(ctr);
        repl = 1'b0;
        for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
                wr = cr + dy;
                wc = cc + dx;
                if (dy == 0 && dx == 0) continue;
                if (tr + dy < 0 || tr + dy >= h || tc + dx < 0 || tc + dx >= w) continue;
                if (wr < 0 || wr > 2 || wc < 0 || wc > 2) continue;
                q = win[wr][wc];
                ad = 0; nd = 0;
                for (int k = 0; k < 3; k++) begin
                    da = alb_of(q, k) - alb_of(ctr, k);
                    dn = nrm_of(q, k) - nrm_of(ctr, k);
                    ad += longint'(da * da);
                    nd += longint'(dn * dn);
                end
                if (!(ad < alb_lim && nd < nrm_lim)) continue;
                gv = gray_of(q);
                n++;
                s += gv;
                p2 += gv * gv;
                for (int k = 0; k < 3; k++) sum[k] += rad_of(q, k);
            end
        end
        if (n == 1) begin
            repl = (g != s);
        end else if (n >= 2) begin
            ng  = n * g;
            d   = (ng > s) ? ng - s : s - ng;
            lhs = 256 * (n - 1) * d * d;
            f   = dev_factor;
            rhs = f * f * n * (n * p2 - s * s);
            repl = lhs > rhs;
        end
        res.out_red      = repl ? 16'((sum[0] + n / 2) / n) : ctr.radiance_red;
        res.out_green    = repl ? 16'((sum[1] + n / 2) / n) : ctr.radiance_green;
        res.out_blue     = repl ? 16'((sum[2] + n / 2) / n) : ctr.radiance_blue;
        res.was_replaced = repl;
        res.last_of_run  = 1'b0;
        res.end_of_frame = (tr == h - 1 && tc == w - 1);
        return res;
    endfunction

    task automatic predict_pixel(pixel_t p);
        result_t outs[$];
        result_t tmp;
        int      w, h, c, r, cc, tc;
        w = eff_width();
        h = eff_height();
        c = (col_pos >= w) ? 0 : col_pos;
        r = (row_pos >= h) ? 0 : row_pos;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = upper_line[c];
        win[1][2] = middle_line[c];
        win[2][2] = p;
        upper_line[c] = win[1][2];
        middle_line[c] = p;
        for (int t = 0; t < 2; t++) begin
            cc = (t == 0) ? 1 : 2;
            tc = (t == 0) ? c - 1 : c;
            if (t == 0 && c < 1) continue;
            if (t == 1 && c != w - 1) continue;
            if (r >= 1) outs.push_back(judge_pixel(1, cc, r - 1, tc, w, h));
            if (r == h - 1) outs.push_back(judge_pixel(2, cc, r, tc, w, h));
        end
        if (outs.size() > 0) begin
            tmp = outs[outs.size() - 1];
            tmp.last_of_run = 1'b1;
            outs[outs.size() - 1] = tmp;
        end
        foreach (outs[i]) expected_results.push_back(outs[i]);
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    function automatic void check_field(string name, longint e, longint a);
        if (e != a) begin
            $error("%s mismatch: expected %0d, got %0d", name, e, a);
            error_count++;
        end
    endfunction

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // prediction, configuration mirror and result checking
    always @(posedge clk) begin
        result_t e;
        if (rst_n && result_valid && !result_stall) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing expected");
                error_count++;
            end else begin
                e = expected_results.pop_front();
                check_field("out_red", e.out_red, result.out_red);
                check_field("out_green", e.out_green, result.out_green);
                check_field("out_blue", e.out_blue, result.out_blue);
                check_field("was_replaced", e.was_replaced, result.was_replaced);
                check_field("last_of_run", e.last_of_run, result.last_of_run);
                check_field("end_of_frame", e.end_of_frame, result.end_of_frame);
                results_checked++;
                if (result.was_replaced) replaced_seen++;
            end
        end
        if (rst_n && cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_FRAME_WIDTH:
                begin
                    fr_width = cfg_data[12:0];
                    col_pos = 0;
                    row_pos = 0;
                end
                CFG_FRAME_HEIGHT:
                begin
                    fr_height = cfg_data[12:0];
                    col_pos = 0;
                    row_pos = 0;
                end
                CFG_ALBEDO_LIMIT:     alb_lim = cfg_data;
                CFG_NORMAL_LIMIT:     nrm_lim = cfg_data;
                CFG_DEVIATION_FACTOR: dev_factor = cfg_data[7:0];
                default:;
            endcase
        end
        pix_taken <= pixel_valid && !pixel_stall;
        if (rst_n && pixel_valid && !pixel_stall) begin
            predict_pixel(pixel);
            items_sent++;
        end
    end

    always @(negedge clk) begin
        if (rst_n && (!pixel_valid || pix_taken)) begin
            if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle) begin
                pixel <= pending_pixels.pop_front();
                pixel_valid <= 1'b1;
            end else begin
                pixel_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (hold_left > 0) begin
            result_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            result_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(int w, int h, logic [31:0] al, logic [31:0] nl, int f);
        write_reg(CFG_FRAME_WIDTH, 32'(w));
        write_reg(CFG_FRAME_HEIGHT, 32'(h));
        write_reg(CFG_ALBEDO_LIMIT, al);
        write_reg(CFG_NORMAL_LIMIT, nl);
        write_reg(CFG_DEVIATION_FACTOR, 32'(f));
    endtask

    // wait for the block to drain before the next register write
    task automatic drain();
        while (pending_pixels.size() > 0 || pixel_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [15:0] jitter16(logic [15:0] v, int amt);
        return v + 16'($urandom_range(2 * amt)) - 16'(amt);
    endfunction

    function automatic pixel_t make_pixel(int noise_pct);
        pixel_t p;
        if ($urandom_range(99) < noise_pct) begin
            p = 141'({$urandom, $urandom, $urandom, $urandom, $urandom});
        end else begin
            if ($urandom_range(99) < 12) begin
                p.radiance_red   = 16'($urandom_range(65535, 40000));
                p.radiance_green = 16'($urandom_range(65535, 40000));
                p.radiance_blue  = 16'($urandom_range(65535, 40000));
            end else begin
                p.radiance_red   = jitter16(base_rad, 200);
                p.radiance_green = jitter16(base_rad, 200);
                p.radiance_blue  = jitter16(base_rad, 200);
            end
            p.albedo_red   = 15'(jitter16(16'(base_alb), 300));
            p.albedo_green = 15'(jitter16(16'(base_alb), 300));
            p.albedo_blue  = 15'(jitter16(16'(base_alb), 300));
            p.normal_x     = jitter16(base_nrm, 500);
            p.normal_y     = jitter16(base_nrm, 500);
            p.normal_z     = jitter16(16'(0) - base_nrm, 500);
        end
        return p;
    endfunction

    task automatic random_phase(int w, int h, logic [31:0] al, logic [31:0] nl, int f,
                                int count, int noise_pct, int mode, int hold);
        drain();
        configure(w, h, al, nl, f);
        case (mode)
            0:       begin send_idle = 7;  recv_idle = 58; end
            1:       begin send_idle = 58; recv_idle = 7;  end
            default: begin send_idle = 0;  recv_idle = 0;  end
        endcase
        base_rad = 16'($urandom_range(3000, 300));
        base_alb = 15'($urandom_range(15000, 1000));
        base_nrm = 16'($urandom_range(10000, 1000));
        for (int i = 0; i < count; i++) pending_pixels.push_back(make_pixel(noise_pct));
        hold_left = hold;
    endtask

    initial begin
        pixel_t p;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // 1x1 frames from zero geometry: field extremes pass straight through
        configure(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 255);
        pending_pixels.push_back('0);
        pending_pixels.push_back({16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF, 15'h7FFF,
                                  16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
        pending_pixels.push_back({16'h0001, 16'h8000, 16'h0100, 15'h4000, 15'h4000, 15'h0,
                                  16'sh8000, 16'sh8000, 16'sh8000});
        pending_pixels.push_back({16'h0002, 16'h0000, 16'hFFFF, 15'h0, 15'h4000, 15'h4000,
                                  16'shC000, 16'sh4000, 16'sh0});
        // 2x1 frame: one neighbor, zero albedo and normal distance
        drain();
        configure(2, 1, 32'd26843546, 32'd26843546, 48);
        pending_pixels.push_back({16'h0100, 16'h0100, 16'h0100, 15'h2000, 15'h2000, 15'h2000,
                                  16'sh0, 16'sh0, 16'sh4000});
        pending_pixels.push_back({16'h0400, 16'h0100, 16'h0100, 15'h2000, 15'h2000, 15'h2000,
                                  16'sh0, 16'sh0, 16'sh4000});
        // 3x3 frame: flat surface with a bright center
        drain();
        write_reg(CFG_SPARE, 32'hFFFF_FFFF);
        configure(3, 3, 32'd26843546, 32'd26843546, 48);
        for (int i = 0; i < 9; i++) begin
            p = {16'h0200, 16'h0180, 16'h0100, 15'h3000, 15'h2000, 15'h1000,
                 16'sh0, 16'sh2000, 16'sh3000};
            if (i == 4) begin
                p.radiance_red   = 16'hFFFF;
                p.radiance_green = 16'hF000;
                p.radiance_blue  = 16'hE000;
            end
            pending_pixels.push_back(p);
        end

        random_phase(4, 3, 32'd26843546, 32'd26843546, 48, 60, 10, 0, 0);
        random_phase(5, 4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 60, 15, 0, 0);
        random_phase(3, 3, 32'd4000000, 32'd4000000, 255, 54, 10, 0, 3000);
        random_phase(8191, 1, 32'd0, 32'd0, 16, 12, 20, 1, 0);
        random_phase(2, 8191, 32'd26843546, 32'd26843546, 48, 24, 10, 1, 0);
        random_phase(7, 5, 32'd26843546, 32'd26843546, 32, 105, 10, 1, 0);
        random_phase(1, 6, 32'd80000000, 32'd80000000, 20, 24, 10, 2, 0);
        random_phase(6, 1, 32'd26843546, 32'hC000_0000, 64, 30, 10, 2, 0);
        random_phase(4, 4, 32'($urandom_range(60000000, 1000000)),
                     32'($urandom_range(60000000, 1000000)), 40, 96, 10, 2, 0);
        drain();

        $display("covered %0d pixels over frame shapes from 1x1 to 4096 wide and tall,",
                 items_sent);
        $display("checked %0d results, %0d of them replaced", results_checked, replaced_seen);
        if (error_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
